>>> rtl/core/rsmp_pkg.sv
// Shared constants, types and helpers of the reservoir sampler.
package rsmp_pkg;

   localparam int unsigned RES_DEPTH  = 256;
   localparam int unsigned SLOT_W     = $clog2(RES_DEPTH);
   localparam int unsigned SIZE_W     = 9;
   localparam int unsigned VALUE_W    = 32;
   localparam int unsigned RAND_W     = 32;
   localparam int unsigned COUNT_W    = 32;
   localparam int unsigned SUM_W      = 64;
   localparam int unsigned REQ_DATA_W = 96;
   localparam int unsigned RSP_DATA_W = 168;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef struct packed {
      logic              keep;
      logic [SLOT_W-1:0] slot;
   } decision_type;

   // Limit a written sample size to 1..RES_DEPTH.
   function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] raw);
      logic [SIZE_W-1:0] n;
      n = raw;
      if (raw == '0) begin
         n = SIZE_W'(1);
      end else if (raw > SIZE_W'(RES_DEPTH)) begin
         n = SIZE_W'(RES_DEPTH);
      end
      return n;
   endfunction

endpackage

>>> rtl/core/rsmp_decide.sv
// Keep decision and slot choice for one word of the stream.
module rsmp_decide (
   input  logic [rsmp_pkg::COUNT_W-1:0] count,
   input  logic [rsmp_pkg::SIZE_W-1:0]  size,
   input  logic [rsmp_pkg::RAND_W-1:0]  accept_random,
   input  logic [rsmp_pkg::RAND_W-1:0]  slot_random,
   output rsmp_pkg::decision_type       decision
);

   logic                                         filling;
   logic [rsmp_pkg::RAND_W+rsmp_pkg::COUNT_W-1:0] accept_prod;
   logic [rsmp_pkg::RAND_W+rsmp_pkg::SIZE_W-1:0]  slot_prod;
   logic [rsmp_pkg::COUNT_W-1:0]                  fill_slot;
   logic                                          replace;

   assign filling     = count <= rsmp_pkg::COUNT_W'(size);
   assign accept_prod = rsmp_pkg::COUNT_W'(accept_random) * count
                        + (rsmp_pkg::RAND_W+rsmp_pkg::COUNT_W)'(0);
   assign slot_prod   = (rsmp_pkg::RAND_W+rsmp_pkg::SIZE_W)'(slot_random)
                        * (rsmp_pkg::RAND_W+rsmp_pkg::SIZE_W)'(size);
   assign fill_slot   = count - rsmp_pkg::COUNT_W'(1);
   // accept_random*count < size*2^32 exactly when the upper half is below size
   assign replace     = accept_prod[rsmp_pkg::RAND_W+rsmp_pkg::COUNT_W-1:rsmp_pkg::RAND_W]
                        < rsmp_pkg::COUNT_W'(size);

   always_comb begin
      decision = '0;
      if (filling) begin
         decision.keep = 1'b1;
         decision.slot = fill_slot[rsmp_pkg::SLOT_W-1:0];
      end else if (replace) begin
         decision.keep = 1'b1;
         decision.slot = slot_prod[rsmp_pkg::RAND_W +: rsmp_pkg::SLOT_W];
      end
   end

endmodule

>>> rtl/core/reservoir_sampler.sv
// Reservoir sampler top level: handshakes, reservoir memory, counters and sums.
// Keeps a uniform sample (Algorithm R) of a stream of signed 32-bit words in a
// 256-entry reservoir and returns, for every word, the keep decision, the slot
// written, the saturating item count, the wrapping stream sum and the sum of
// the values held. One word is taken every cycle unless the result side stalls;
// its result is registered; the reservoir memory is read and written once per
// word at the same edge, and the reservoir sum is formed one stage later from
// the registered read data. No clearing pass is needed after reset: per-slot
// valid bits, cleared by reset and by new_stream, track which entries count.
// csr_data sets the sample size; 0 acts as 1 and values above 256 act as 256.
module reservoir_sampler (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // sample_value, accept_random, slot_random
   input  logic [rsmp_pkg::REQ_DATA_W-1:0]   req_tdata,
   // new_stream
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // slot_index, items_seen, stream_sum, reservoir_sum
   output logic [rsmp_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // kept
   output logic                              rsp_tuser,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [rsmp_pkg::SIZE_W-1:0]       csr_data
);

   // configuration
   logic [rsmp_pkg::SIZE_W-1:0]   size_ff;

   // input stage
   logic                          s1_valid_ff;
   logic [rsmp_pkg::VALUE_W-1:0]  s1_value_ff;
   logic [rsmp_pkg::RAND_W-1:0]   s1_acc_ff;
   logic [rsmp_pkg::RAND_W-1:0]   s1_slot_ff;
   logic                          s1_restart_ff;

   // stream state
   logic [rsmp_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic [rsmp_pkg::SUM_W-1:0]    ssum_ff, ssum_in;
   logic [rsmp_pkg::SUM_W-1:0]    rsum_ff, rsum_in;
   logic [rsmp_pkg::RES_DEPTH-1:0] valid_ff, valid_in;
   logic [rsmp_pkg::VALUE_W-1:0]  mem [rsmp_pkg::RES_DEPTH];

   // second stage
   logic                          s2_valid_ff;
   logic                          s2_keep_ff;
   logic [rsmp_pkg::SLOT_W-1:0]   s2_slot_ff;
   logic [rsmp_pkg::COUNT_W-1:0]  s2_count_ff;
   logic [rsmp_pkg::SUM_W-1:0]    s2_ssum_ff;
   logic [rsmp_pkg::VALUE_W-1:0]  s2_value_ff;
   logic                          s2_restart_ff;
   logic                          s2_old_valid_ff;
   logic [rsmp_pkg::VALUE_W-1:0]  s2_old_ff;

   // result register
   logic                          rsp_valid_ff;
   logic                          rsp_kept_ff;
   logic [rsmp_pkg::SLOT_W-1:0]   rsp_slot_ff;
   logic [rsmp_pkg::COUNT_W-1:0]  rsp_count_ff;
   logic [rsmp_pkg::SUM_W-1:0]    rsp_ssum_ff;
   logic [rsmp_pkg::SUM_W-1:0]    rsp_rsum_ff;

   logic                          rsp_free;
   logic                          s2_ready;
   logic                          s1_ready;
   logic                          req_take;
   logic                          s1_move;
   logic                          s2_move;
   rsmp_pkg::decision_type        decision;
   logic                          old_valid;
   logic [rsmp_pkg::VALUE_W:0]    delta;

   // handshake chain
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign s2_ready   = !s2_valid_ff || rsp_free;
   assign s1_ready   = !s1_valid_ff || s2_ready;
   assign req_tready = s1_ready;
   assign req_take   = req_tvalid && s1_ready;
   assign s1_move    = s1_valid_ff && s2_ready;
   assign s2_move    = s2_valid_ff && rsp_free;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= rsmp_pkg::SIZE_W'(rsmp_pkg::RES_DEPTH);
      end else if (csr_valid) begin
         size_ff <= rsmp_pkg::eff_size(csr_data);
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_value_ff   <= req_tdata[31:0];
         s1_acc_ff     <= req_tdata[63:32];
         s1_slot_ff    <= req_tdata[95:64];
         s1_restart_ff <= req_tuser;
      end
   end

   // count advances first, saturating, and restarts at one on a new stream
   always_comb begin
      if (s1_restart_ff) begin
         count_in = rsmp_pkg::COUNT_W'(1);
      end else if (count_ff == rsmp_pkg::COUNT_MAX) begin
         count_in = count_ff;
      end else begin
         count_in = count_ff + rsmp_pkg::COUNT_W'(1);
      end
   end

   rsmp_decide u_decide (
      .count         (count_in),
      .size          (size_ff),
      .accept_random (s1_acc_ff),
      .slot_random   (s1_slot_ff),
      .decision      (decision)
   );

   assign ssum_in   = (s1_restart_ff ? '0 : ssum_ff)
                      + rsmp_pkg::SUM_W'(signed'(s1_value_ff));
   assign old_valid = !s1_restart_ff && valid_ff[decision.slot];

   always_comb begin
      valid_in = s1_restart_ff ? '0 : valid_ff;
      if (decision.keep) begin
         valid_in[decision.slot] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ssum_ff  <= '0;
         valid_ff <= '0;
      end else if (s1_move) begin
         count_ff <= count_in;
         ssum_ff  <= ssum_in;
         valid_ff <= valid_in;
      end
   end

   // reservoir: read old slot value and write the new one at the same edge
   always_ff @(posedge clock) begin
      if (s1_move) begin
         s2_old_ff <= mem[decision.slot];
         if (decision.keep) begin
            mem[decision.slot] <= s1_value_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         s2_keep_ff      <= decision.keep;
         s2_slot_ff      <= decision.slot;
         s2_count_ff     <= count_in;
         s2_ssum_ff      <= ssum_in;
         s2_value_ff     <= s1_value_ff;
         s2_restart_ff   <= s1_restart_ff;
         s2_old_valid_ff <= old_valid;
      end
   end

   // swap the displaced value for the new one in the reservoir sum
   always_comb begin
      delta = '0;
      if (s2_keep_ff) begin
         delta = (rsmp_pkg::VALUE_W+1)'(signed'(s2_value_ff));
         if (s2_old_valid_ff) begin
            delta = delta - (rsmp_pkg::VALUE_W+1)'(signed'(s2_old_ff));
         end
      end
      rsum_in = (s2_restart_ff ? '0 : rsum_ff) + rsmp_pkg::SUM_W'(signed'(delta));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsum_ff <= '0;
      end else if (s2_move) begin
         rsum_ff <= rsum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_free) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_move) begin
         rsp_kept_ff  <= s2_keep_ff;
         rsp_slot_ff  <= s2_keep_ff ? s2_slot_ff : '0;
         rsp_count_ff <= s2_count_ff;
         rsp_ssum_ff  <= s2_ssum_ff;
         rsp_rsum_ff  <= rsum_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kept_ff;
   assign rsp_tdata  = {rsp_rsum_ff, rsp_ssum_ff, rsp_count_ff, rsp_slot_ff};

   // a kept word always lands inside the slots in use
   a_slot_in_range: assert property (@(posedge clock) disable iff (reset)
      s1_move && decision.keep |-> rsmp_pkg::SIZE_W'(decision.slot) < size_ff)
      else $error("slot outside sample size");

   // a new stream restarts the count at one
   a_restart_count: assert property (@(posedge clock) disable iff (reset)
      s1_move && s1_restart_ff |=> count_ff == rsmp_pkg::COUNT_W'(1))
      else $error("count not restarted");

   // a dropped word leaves the slot marks alone
   a_drop_keeps_valid: assert property (@(posedge clock) disable iff (reset)
      s1_move && !decision.keep && !s1_restart_ff |=> $stable(valid_ff))
      else $error("valid bits changed on a dropped word");

   // every result carries a nonzero count
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_count_ff != '0)
      else $error("result with zero count");

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the reservoir sampler: random and directed words, scoreboard check.
typedef struct {
   logic        kept;
   logic [7:0]  slot;
   logic [31:0] seen;
   logic [63:0] stream_total;
   logic [63:0] held_total;
} sample_outcome_type;

class sample_scoreboard;
   logic [31:0]        held_value [rsmp_pkg::RES_DEPTH];
   bit                 held_live  [rsmp_pkg::RES_DEPTH];
   logic [31:0]        seen_count;
   logic [63:0]        stream_total;
   logic [63:0]        held_total;
   logic [8:0]         size_reg;
   sample_outcome_type awaited [$];
   int                 failures;
   int                 results;
   int                 kept_total;

   function new();
      foreach (held_live[i]) held_live[i] = 0;
      seen_count   = '0;
      stream_total = '0;
      held_total   = '0;
      size_reg     = 9'd256;
      failures     = 0;
      results      = 0;
      kept_total   = 0;
   endfunction

   function void set_size(logic [8:0] n);
      size_reg = n;
   endfunction

   function int pending();
      return awaited.size();
   endfunction

   function void note_word(logic [31:0] value, logic [31:0] acc_r, logic [31:0] slot_r,
                           logic restart);
      logic [63:0]        n;
      logic [63:0]        slot;
      logic [63:0]        old_ext;
      bit                 keep;
      sample_outcome_type want;
      n = (size_reg == 9'd0) ? 64'd1 :
          (size_reg > 9'(rsmp_pkg::RES_DEPTH)) ? 64'(rsmp_pkg::RES_DEPTH) : 64'(size_reg);
      if (restart) begin
         seen_count   = '0;
         stream_total = '0;
         held_total   = '0;
         foreach (held_live[i]) held_live[i] = 0;
      end
      if (seen_count != 32'hffff_ffff) seen_count = seen_count + 32'd1;
      keep = 0;
      slot = '0;
      if (64'(seen_count) <= n) begin
         slot = 64'(seen_count) - 64'd1;
         keep = 1;
      end else if (64'(acc_r) * 64'(seen_count) < (n << 32)) begin
         slot = (64'(slot_r) * n) >> 32;
         keep = 1;
      end
      if (keep) begin
         if (held_live[slot[7:0]]) begin
            old_ext    = {{32{held_value[slot[7:0]][31]}}, held_value[slot[7:0]]};
            held_total = held_total - old_ext;
         end
         held_value[slot[7:0]] = value;
         held_live[slot[7:0]]  = 1;
         held_total            = held_total + {{32{value[31]}}, value};
      end else begin
         slot = '0;
      end
      stream_total      = stream_total + {{32{value[31]}}, value};
      want.kept         = keep;
      want.slot         = slot[7:0];
      want.seen         = seen_count;
      want.stream_total = stream_total;
      want.held_total   = held_total;
      awaited.push_back(want);
   endfunction

   task report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch on result %0d: %s got %h want %h", results, what, got, want);
      failures++;
   endtask

   task check_result(sample_outcome_type got);
      sample_outcome_type want;
      if (awaited.size() == 0) begin
         report("unexpected word", 64'(got.seen), 64'd0);
      end else begin
         want = awaited.pop_front();
         if (got.kept !== want.kept) report("kept", 64'(got.kept), 64'(want.kept));
         if (got.slot !== want.slot) report("slot_index", 64'(got.slot), 64'(want.slot));
         if (got.seen !== want.seen) report("items_seen", 64'(got.seen), 64'(want.seen));
         if (got.stream_total !== want.stream_total)
            report("stream_sum", got.stream_total, want.stream_total);
         if (got.held_total !== want.held_total)
            report("reservoir_sum", got.held_total, want.held_total);
         if (want.kept) kept_total++;
      end
      results++;
   endtask
endclass

module testbench;
   logic                            clock;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [rsmp_pkg::REQ_DATA_W-1:0] req_tdata;
   logic                            req_tuser;
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic [rsmp_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            rsp_tuser;
   logic                            csr_valid;
   logic                            csr_ready;
   logic [rsmp_pkg::SIZE_W-1:0]     csr_data;

   sample_scoreboard sb;
   bit               no_idle;
   bit               hold_done;
   int               hold_left;
   int               words_sent;
   int               sizes_used;

   reservoir_sampler i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("timeout waiting for results");
      $display("reservoir_sampler test failed");
      $finish;
   end

   // Result side: random back-pressure, one long hold-off.
   initial begin
      sample_outcome_type got;
      rsp_tready = 1'b0;
      hold_done  = 0;
      hold_left  = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got.kept         = rsp_tuser;
            got.slot         = rsp_tdata[7:0];
            got.seen         = rsp_tdata[39:8];
            got.stream_total = rsp_tdata[103:40];
            got.held_total   = rsp_tdata[167:104];
            sb.check_result(got);
         end
         if (!hold_done && sb.results >= 350) begin
            hold_done = 1;
            hold_left = 250;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= no_idle || ($urandom_range(99) >= 30);
         end
      end
   end

   task automatic send_word(input logic [31:0] value, input logic [31:0] acc_r,
                            input logic [31:0] slot_r, input logic restart);
      while (!no_idle && $urandom_range(99) < 30) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {slot_r, acc_r, value};
      req_tuser  <= restart;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_word(value, acc_r, slot_r, restart);
      words_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_size(input logic [8:0] n);
      csr_valid <= 1'b1;
      csr_data  <= n;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_size(n);
      sizes_used++;
      csr_valid <= 1'b0;
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(9))
         0:       return 32'h7fff_ffff;
         1:       return 32'h8000_0000;
         2:       return 32'hffff_ffff;
         3:       return 32'h0000_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_fraction();
      case ($urandom_range(9))
         0:       return 32'h0000_0000;
         1:       return 32'hffff_ffff;
         2:       return $urandom_range(255);
         default: return $urandom;
      endcase
   endfunction

   initial begin
      logic [8:0] phase_size [10];
      sb         = new();
      no_idle    = 0;
      words_sent = 0;
      sizes_used = 0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      csr_valid  = 1'b0;
      csr_data   = '0;
      phase_size = '{9'd0, 9'd1, 9'd256, 9'd511, 9'd2, 9'd257, 9'd16, 9'd3, 9'd128, 9'd64};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_size(9'd4);
      send_word(32'h7fff_ffff, 32'h0000_0000, 32'h0000_0000, 1'b1);
      send_word(32'h8000_0000, 32'hffff_ffff, 32'hffff_ffff, 1'b0);
      send_word(32'h0000_0000, 32'hffff_ffff, 32'h0000_0000, 1'b0);
      send_word(32'hffff_ffff, 32'h0000_0000, 32'hffff_ffff, 1'b0);
      send_word(32'h1234_5678, 32'h0000_0000, 32'hffff_ffff, 1'b0);
      send_word(32'h7fff_ffff, 32'hffff_ffff, 32'h0000_0000, 1'b0);
      send_word(32'h8000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
      send_word(32'h0000_0001, 32'h7fff_ffff, 32'h8000_0000, 1'b0);
      send_word(32'hdead_beef, 32'h71c7_1c71, 32'hc000_0000, 1'b0);
      send_word(32'h5555_aaaa, 32'h6666_6667, 32'h4000_0000, 1'b0);
      send_word(32'h7fff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b1);
      send_word(32'h8000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
      drain();

      for (int p = 0; p < 10; p++) begin
         write_size(phase_size[p]);
         no_idle = (p == 2);
         for (int k = 0; k < 84; k++) begin
            if (p == 4 && k == 40) drain();
            send_word(pick_value(), pick_fraction(), $urandom, $urandom_range(39) == 0);
         end
         drain();
      end
      no_idle = 0;
      repeat (10) @(posedge clock);

      $display("sent %0d words over %0d sample-size settings", words_sent, sizes_used);
      $display("checked %0d results, %0d of them kept", sb.results, sb.kept_total);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("reservoir_sampler test passed");
      end else begin
         $display("reservoir_sampler test failed");
      end
      $finish;
   end
endmodule

>>> filelist.f
rtl/core/rsmp_pkg.sv
rtl/core/rsmp_decide.sv
rtl/core/reservoir_sampler.sv
tb/testbench.sv
